// ===== sv/tfm_pkg.sv =====
// Package for the thruster force/torque mixer: payload structs, fixed-point widths,
// configuration register indexes and the output saturation function.
// No dependencies.
package tfm_pkg;

  // Field widths and fixed-point formats
  localparam int CMD_W     = 16;            // commands, signed Q3.12
  localparam int CMD_FRAC  = 12;
  localparam int OUT_W     = 32;            // results, signed Q15.16
  localparam int Q_FRAC    = 16;            // coefficient and geometry fraction bits
  localparam int COEF_W    = 18;            // curve coefficients, signed Q1.16
  localparam int LEV_W     = 16;            // lever arms, unsigned Q0.16
  localparam int TRIG_W    = 17;            // cos/sin, unsigned Q1.16
  localparam int CFG_W     = 18;            // widest register
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_QUAD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_LIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVER_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVER_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVER_Z    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_COS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_SIN  = 3'd6;

  // Thrust curve datapath widths
  localparam int MAG_W     = CMD_W;                   // |cmd| fits unsigned
  localparam int SQ_W      = 2 * CMD_W - 1;           // |cmd|^2
  localparam int BM_W      = COEF_W + CMD_W + 1;      // b * |cmd|
  localparam int PA_W      = COEF_W + SQ_W + 1;       // a * |cmd|^2, Q.40
  localparam int THR_SHIFT = 2 * CMD_FRAC;            // Q.40 -> Q.16
  localparam int T_W       = PA_W - THR_SHIFT + 1;    // signed thrust, Q.16

  // Mixing datapath widths
  localparam int S_W       = T_W + 2;                 // sum of four thrusts
  localparam int P_W       = S_W + COEF_W;            // geometry * sum, Q.32
  localparam int LSC_W     = LEV_W + TRIG_W + 1;      // lx*s + ly*c, Q.32
  localparam int LSC_SPLIT = 17;                      // yaw product split point
  localparam int TZ_W      = P_W + LSC_SPLIT + 1;     // yaw torque, Q.48
  localparam int RW        = TZ_W - 2 * Q_FRAC + 1;   // rounded values before clipping

  localparam int STG_THR   = 4;                       // stages inside the thrust unit
  localparam int NSTG      = 8;                       // stages from input to output register

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd_vert_front_left;
    logic signed [CMD_W-1:0] cmd_vert_front_right;
    logic signed [CMD_W-1:0] cmd_vert_rear_left;
    logic signed [CMD_W-1:0] cmd_vert_rear_right;
    logic signed [CMD_W-1:0] cmd_horiz_front_left;
    logic signed [CMD_W-1:0] cmd_horiz_front_right;
    logic signed [CMD_W-1:0] cmd_horiz_rear_left;
    logic signed [CMD_W-1:0] cmd_horiz_rear_right;
  } tfm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic signed [OUT_W-1:0] torque_x;
    logic signed [OUT_W-1:0] torque_y;
    logic signed [OUT_W-1:0] torque_z;
    logic                    saturated;
  } tfm_out_t;

  // Clip a rounded value to OUT_W bits; the top bit of the result flags a clip
  function automatic logic [OUT_W:0] sat_clip(input logic signed [RW-1:0] x);
    logic over;
    over = (x[RW-1:OUT_W-1] != {(RW-OUT_W+1){1'b0}}) &&
           (x[RW-1:OUT_W-1] != {(RW-OUT_W+1){1'b1}});
    if (!over) begin
      return {1'b0, x[OUT_W-1:0]};
    end else if (x[RW-1]) begin
      return {1'b1, OUT_MIN};
    end else begin
      return {1'b1, OUT_MAX};
    end
  endfunction

endpackage

// ===== sv/thruster_force_torque_mixer.sv =====
// Thruster force/torque mixer: an accepted transaction reaches out_valid through
// four thrust-curve stages, then sum, geometry multiply, round and clip/output.
// Throughput one transaction per cycle unless stalled; each stage advances when it
// is empty or its successor advances, so a stalled output still absorbs bubbles
// upstream. Synchronous active-low reset clears all valid bits and loads the
// register defaults; geometry products are refreshed every cycle from the registers.
module thruster_force_torque_mixer import tfm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tfm_in_t              in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output tfm_out_t             out_data,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic signed [P_W-1:0] P_HALF  = P_W'(64'd1 << (Q_FRAC - 1));
  localparam logic signed [P_W-1:0] TZ_HALF = P_W'(64'd1 << (2 * Q_FRAC - 1));

  // configuration registers
  logic signed [COEF_W-1:0] quad_r, lin_r;
  logic [LEV_W-1:0]         lx_r, ly_r, lz_r;
  logic [TRIG_W-1:0]        cos_r, sin_r;
  logic [LEV_W+TRIG_W-1:0]  lxs_r, lyc_r;
  logic [LSC_W-1:0]         lsc_r;

  // pipeline control
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  // thrust unit hookup
  logic signed [CMD_W-1:0] cmd_arr [8];
  logic signed [T_W-1:0]   thr    [8];

  // stage 5: sums
  logic signed [S_W-1:0] sfx_r, sfy_r, sfz_r, stx_r, sty_r, stz_r;
  logic signed [S_W-1:0] t_s    [8];
  // stage 6: products
  logic signed [P_W-1:0] pfx_r, pfy_r, ptx_r, pty_r, tzlo_r, tzhi_r;
  logic signed [S_W-1:0] sfz6_r;
  // stage 7: rounded values
  logic signed [TZ_W-1:0] tz_full;
  logic signed [RW-1:0]   rfx_r, rfy_r, rfz_r, rtx_r, rty_r, rtz_r;
  // stage 8: clip
  logic [OUT_W:0] cfx, cfy, cfz, ctx, cty, ctz;
  tfm_out_t       out_r, out_nxt;

  // Configuration writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r <= COEF_W'(3559);
      lin_r  <= COEF_W'(210);
      lx_r   <= LEV_W'(26214);
      ly_r   <= LEV_W'(13107);
      lz_r   <= LEV_W'(26214);
      cos_r  <= TRIG_W'(46341);
      sin_r  <= TRIG_W'(46341);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CURVE_QUAD: quad_r <= $signed(cfg_data[COEF_W-1:0]);
        CFG_CURVE_LIN:  lin_r  <= $signed(cfg_data[COEF_W-1:0]);
        CFG_LEVER_X:    lx_r   <= cfg_data[LEV_W-1:0];
        CFG_LEVER_Y:    ly_r   <= cfg_data[LEV_W-1:0];
        // vertical depth is stored but never read; it cancels out of every torque
        CFG_LEVER_Z:    lz_r   <= cfg_data[LEV_W-1:0];
        CFG_HORIZ_COS:  cos_r  <= cfg_data[TRIG_W-1:0];
        CFG_HORIZ_SIN:  sin_r  <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Yaw lever of the horizontal thrusters, refreshed from the registers
  always_ff @(posedge clk) begin
    lxs_r <= lx_r * sin_r;
    lyc_r <= ly_r * cos_r;
    lsc_r <= LSC_W'(lxs_r) + LSC_W'(lyc_r);
  end

  // Advance chain: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stages 1-4: one thrust curve per thruster
  assign cmd_arr[0] = in_data.cmd_vert_front_left;
  assign cmd_arr[1] = in_data.cmd_vert_front_right;
  assign cmd_arr[2] = in_data.cmd_vert_rear_left;
  assign cmd_arr[3] = in_data.cmd_vert_rear_right;
  assign cmd_arr[4] = in_data.cmd_horiz_front_left;
  assign cmd_arr[5] = in_data.cmd_horiz_front_right;
  assign cmd_arr[6] = in_data.cmd_horiz_rear_left;
  assign cmd_arr[7] = in_data.cmd_horiz_rear_right;

  for (genvar g = 0; g < 8; g++) begin : g_thr
    tfm_thrust u_thrust (
      .clk    (clk),
      .adv    (adv[STG_THR-1:0]),
      .cmd    (cmd_arr[g]),
      .quad   (quad_r),
      .lin    (lin_r),
      .thrust (thr[g])
    );
    assign t_s[g] = S_W'(thr[g]);
  end

  // Stage 5: combine thrusts per axis
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sfx_r <= t_s[4] + t_s[5] - t_s[6] - t_s[7];
      sfy_r <= t_s[4] - t_s[5] + t_s[6] - t_s[7];
      sfz_r <= t_s[0] + t_s[1] + t_s[2] + t_s[3];
      stx_r <= -t_s[0] + t_s[1] - t_s[2] + t_s[3];
      sty_r <= -t_s[0] - t_s[1] + t_s[2] + t_s[3];
      stz_r <= t_s[4] - t_s[5] - t_s[6] + t_s[7];
    end
  end

  // Stage 6: scale by geometry, rounding half added to all but the upper yaw product
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      pfx_r  <= $signed({1'b0, cos_r}) * sfx_r + P_HALF;
      pfy_r  <= $signed({1'b0, sin_r}) * sfy_r + P_HALF;
      ptx_r  <= $signed({1'b0, ly_r}) * stx_r + P_HALF;
      pty_r  <= $signed({1'b0, lx_r}) * sty_r + P_HALF;
      tzlo_r <= $signed({1'b0, lsc_r[LSC_SPLIT-1:0]}) * stz_r + TZ_HALF;
      tzhi_r <= $signed({1'b0, lsc_r[LSC_W-1:LSC_SPLIT]}) * stz_r;
      sfz6_r <= sfz_r;
    end
  end

  // Stage 7: join the yaw partial products and floor everything to Q.16
  assign tz_full = (TZ_W'(tzhi_r) <<< LSC_SPLIT) + TZ_W'(tzlo_r);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      rfx_r <= RW'($signed(pfx_r[P_W-1:Q_FRAC]));
      rfy_r <= RW'($signed(pfy_r[P_W-1:Q_FRAC]));
      rfz_r <= RW'(sfz6_r);
      rtx_r <= RW'($signed(ptx_r[P_W-1:Q_FRAC]));
      rty_r <= RW'($signed(pty_r[P_W-1:Q_FRAC]));
      rtz_r <= RW'($signed(tz_full[TZ_W-1:2*Q_FRAC]));
    end
  end

  // Stage 8: clip to the output range and flag any clip
  assign cfx = sat_clip(rfx_r);
  assign cfy = sat_clip(rfy_r);
  assign cfz = sat_clip(rfz_r);
  assign ctx = sat_clip(rtx_r);
  assign cty = sat_clip(rty_r);
  assign ctz = sat_clip(rtz_r);

  always_comb begin
    out_nxt.force_x   = cfx[OUT_W-1:0];
    out_nxt.force_y   = cfy[OUT_W-1:0];
    out_nxt.force_z   = cfz[OUT_W-1:0];
    out_nxt.torque_x  = ctx[OUT_W-1:0];
    out_nxt.torque_y  = cty[OUT_W-1:0];
    out_nxt.torque_z  = ctz[OUT_W-1:0];
    out_nxt.saturated = cfx[OUT_W] | cfy[OUT_W] | cfz[OUT_W] |
                        ctx[OUT_W] | cty[OUT_W] | ctz[OUT_W];
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

endmodule

// ===== sv/tfm_thrust.sv =====
// Four-stage pipelined odd quadratic thrust curve for one thruster command.
// Depends on tfm_pkg; stage enables come from the mixer's valid/stall chain.
module tfm_thrust import tfm_pkg::*; (
  input  logic                     clk,
  input  logic [STG_THR-1:0]       adv,
  input  logic signed [CMD_W-1:0]  cmd,
  input  logic signed [COEF_W-1:0] quad,
  input  logic signed [COEF_W-1:0] lin,
  output logic signed [T_W-1:0]    thrust
);

  localparam logic signed [PA_W-1:0] THR_HALF = PA_W'(64'd1 << (THR_SHIFT - 1));

  logic signed [CMD_W:0]   cmd_ext;
  logic signed [CMD_W:0]   abs_ext;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    neg1_r, neg2_r, neg3_r;
  logic [2*MAG_W-1:0]      sq_full;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic signed [BM_W-1:0]  bm_r, bm_nxt, bm3_r;
  logic signed [PA_W-1:0]  pa_r, pa_nxt;
  logic signed [PA_W-1:0]  x_sum;
  logic signed [T_W-1:0]   t_ext;
  logic signed [T_W-1:0]   thrust_r, thrust_nxt;

  // Stage 1: magnitude and sign, full width so the most negative command stays exact
  assign cmd_ext = {cmd[CMD_W-1], cmd};
  assign abs_ext = cmd[CMD_W-1] ? -cmd_ext : cmd_ext;
  assign mag_nxt = abs_ext[MAG_W-1:0];

  // Stage 2: square and linear term
  assign sq_full = mag_r * mag_r;
  assign sq_nxt  = sq_full[SQ_W-1:0];
  assign bm_nxt  = lin * $signed({1'b0, mag_r});

  // Stage 3: quadratic term with the rounding half folded in
  assign pa_nxt = quad * $signed({1'b0, sq_r}) + THR_HALF;

  // Stage 4: add linear term, drop to Q.16 by floor, restore sign
  assign x_sum      = pa_r + (PA_W'(bm3_r) <<< CMD_FRAC);
  assign t_ext      = T_W'($signed(x_sum[PA_W-1:THR_SHIFT]));
  assign thrust_nxt = neg3_r ? -t_ext : t_ext;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mag_r  <= mag_nxt;
      neg1_r <= cmd[CMD_W-1];
    end
    if (adv[1]) begin
      sq_r   <= sq_nxt;
      bm_r   <= bm_nxt;
      neg2_r <= neg1_r;
    end
    if (adv[2]) begin
      pa_r   <= pa_nxt;
      bm3_r  <= bm_r;
      neg3_r <= neg2_r;
    end
    if (adv[3]) begin
      thrust_r <= thrust_nxt;
    end
  end

  assign thrust = thrust_r;

endmodule

// ===== sv/tfm_chk.sv =====
// Port-level checker for the thruster force/torque mixer, bound to the top level.
// Depends on tfm_pkg for the result struct and output limits.
module tfm_chk import tfm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input tfm_out_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction dropped or changed");

  // Never stall the input while the output register is empty
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output stage");

  // A clip flag means some field sits at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.force_x == OUT_MAX || out_data.force_x == OUT_MIN ||
       out_data.force_y == OUT_MAX || out_data.force_y == OUT_MIN ||
       out_data.force_z == OUT_MAX || out_data.force_z == OUT_MIN ||
       out_data.torque_x == OUT_MAX || out_data.torque_x == OUT_MIN ||
       out_data.torque_y == OUT_MAX || out_data.torque_y == OUT_MIN ||
       out_data.torque_z == OUT_MAX || out_data.torque_z == OUT_MIN))
    else $error("saturated set with no field at a limit");

  // Heave is four thrusts summed, well inside range
  a_heave_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.force_z[OUT_W-1:OUT_W-4] == 4'b0000 ||
                   out_data.force_z[OUT_W-1:OUT_W-4] == 4'b1111))
    else $error("force_z outside the reachable range");

endmodule

bind thruster_force_torque_mixer tfm_chk u_tfm_chk (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for thruster_force_torque_mixer: drives command sets,
// predicts the force/torque results and checks each one as it leaves the block.
// Depends on tfm_pkg (payload structs, widths, register indexes) and the mixer RTL.
`timescale 1ns / 1ps

module testbench;
  import tfm_pkg::*;

  localparam int IDLE_PCT   = 38;
  localparam int HOLD_LEN   = 300;
  localparam int CYCLE_CAP  = 200000;
  localparam int REPORT_MAX = 10;
  // index past the end of the register list; writes to it are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tfm_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tfm_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CURVE_QUAD;
  logic [CFG_W-1:0]     cfg_data = '0;

  // register values the predictor works from, at their reset defaults
  logic signed [COEF_W-1:0] quad_coef = 18'sd3559;
  logic signed [COEF_W-1:0] lin_coef  = 18'sd210;
  logic [LEV_W-1:0]         arm_x     = 16'd26214;
  logic [LEV_W-1:0]         arm_y     = 16'd13107;
  logic [LEV_W-1:0]         arm_z     = 16'd26214;
  logic [TRIG_W-1:0]        mount_cos = 17'd46341;
  logic [TRIG_W-1:0]        mount_sin = 17'd46341;

  tfm_out_t expected_wrench[$];
  int       mismatches = 0;
  int       sets_sent = 0;
  int       wrenches_checked = 0;
  int       settings_used = 1;
  int       cycle_count = 0;
  logic     quiet = 1'b0;
  int       hold_token = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  thruster_force_torque_mixer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Thrust of one thruster in Q.16: odd quadratic curve, rounded half up
  function automatic longint curve_thrust(input logic signed [CMD_W-1:0] cmd);
    longint v;
    longint mag;
    longint x;
    longint t;
    v   = cmd;
    mag = (v < 0) ? -v : v;
    x   = longint'(quad_coef) * mag * mag + longint'(lin_coef) * mag * 4096;
    t   = (x + (64'sd1 <<< 23)) >>> 24;
    return (v < 0) ? -t : t;
  endfunction

  // Round to Q.16 half toward +inf, then clip to the output range
  function automatic logic signed [OUT_W-1:0] round_clip(input longint x, input int sh,
                                                         inout bit clipped);
    longint r;
    r = (x + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > longint'(OUT_MAX)) begin
      r = longint'(OUT_MAX);
      clipped = 1'b1;
    end else if (r < longint'(OUT_MIN)) begin
      r = longint'(OUT_MIN);
      clipped = 1'b1;
    end
    return r[OUT_W-1:0];
  endfunction

  // Body force and torque for one command set under the current registers
  function automatic tfm_out_t mix_wrench(input tfm_in_t cmd);
    longint   t[8];
    longint   lx;
    longint   ly;
    longint   cs;
    longint   sn;
    bit       clipped;
    tfm_out_t w;
    t[0] = curve_thrust(cmd.cmd_vert_front_left);
    t[1] = curve_thrust(cmd.cmd_vert_front_right);
    t[2] = curve_thrust(cmd.cmd_vert_rear_left);
    t[3] = curve_thrust(cmd.cmd_vert_rear_right);
    t[4] = curve_thrust(cmd.cmd_horiz_front_left);
    t[5] = curve_thrust(cmd.cmd_horiz_front_right);
    t[6] = curve_thrust(cmd.cmd_horiz_rear_left);
    t[7] = curve_thrust(cmd.cmd_horiz_rear_right);
    lx = longint'(arm_x);
    ly = longint'(arm_y);
    cs = longint'(mount_cos);
    sn = longint'(mount_sin);
    clipped = 1'b0;
    // vertical depth never shows up: its thrust is parallel to z
    w.force_x   = round_clip(cs * (t[4] + t[5] - t[6] - t[7]), 16, clipped);
    w.force_y   = round_clip(sn * (t[4] - t[5] + t[6] - t[7]), 16, clipped);
    w.force_z   = round_clip((t[0] + t[1] + t[2] + t[3]) * 2, 1, clipped);
    w.torque_x  = round_clip(ly * (-t[0] + t[1] - t[2] + t[3]), 16, clipped);
    w.torque_y  = round_clip(lx * (-t[0] - t[1] + t[2] + t[3]), 16, clipped);
    w.torque_z  = round_clip((lx * sn + ly * cs) * (t[4] - t[5] - t[6] + t[7]), 32,
                             clipped);
    w.saturated = clipped;
    return w;
  endfunction

  // Command value: extremes, zero, small magnitudes or anything at all
  function automatic logic signed [CMD_W-1:0] rand_cmd();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return CMD_W'(int'($urandom_range(64)) - 32);
      default: return CMD_W'($urandom);
    endcase
  endfunction

  function automatic tfm_in_t rand_cmd_set();
    tfm_in_t cmd;
    cmd.cmd_vert_front_left   = rand_cmd();
    cmd.cmd_vert_front_right  = rand_cmd();
    cmd.cmd_vert_rear_left    = rand_cmd();
    cmd.cmd_vert_rear_right   = rand_cmd();
    cmd.cmd_horiz_front_left  = rand_cmd();
    cmd.cmd_horiz_front_right = rand_cmd();
    cmd.cmd_horiz_rear_left   = rand_cmd();
    cmd.cmd_horiz_rear_right  = rand_cmd();
    return cmd;
  endfunction

  // Register value with its range ends weighted up
  function automatic int pick_value(input int lo, input int hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  // Send one command set, predict its result once the transaction is accepted
  task automatic send_cmd(input tfm_in_t cmd);
    // idle each cycle at random, unless quiet, before offering the transaction
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    expected_wrench.push_back(mix_wrench(cmd));
    sets_sent++;
  endtask

  // Write one register and mirror it into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_W-1:0] d;
    d = val[CFG_W-1:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CURVE_QUAD: quad_coef = d[COEF_W-1:0];
      CFG_CURVE_LIN:  lin_coef  = d[COEF_W-1:0];
      CFG_LEVER_X:    arm_x     = d[LEV_W-1:0];
      CFG_LEVER_Y:    arm_y     = d[LEV_W-1:0];
      CFG_LEVER_Z:    arm_z     = d[LEV_W-1:0];
      CFG_HORIZ_COS:  mount_cos = d[TRIG_W-1:0];
      CFG_HORIZ_SIN:  mount_sin = d[TRIG_W-1:0];
      default: ;
    endcase
  endtask

  // Drain the pipeline, then load every register and poke the unused index
  task automatic apply_config(input int quad, input int lin, input int lx, input int ly,
                              input int lz, input int cs, input int sn);
    in_valid <= 1'b0;
    while (expected_wrench.size() != 0) @(posedge clk);
    repeat (NSTG + 2) @(posedge clk);
    write_reg(CFG_CURVE_QUAD, quad);
    write_reg(CFG_CURVE_LIN, lin);
    write_reg(CFG_LEVER_X, lx);
    write_reg(CFG_LEVER_Y, ly);
    write_reg(CFG_LEVER_Z, lz);
    write_reg(CFG_HORIZ_COS, cs);
    write_reg(CFG_HORIZ_SIN, sn);
    write_reg(CFG_UNUSED, int'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic apply_random_config();
    apply_config(pick_value(-131072, 131071), pick_value(-131072, 131071),
                 pick_value(0, 65535), pick_value(0, 65535), pick_value(0, 65535),
                 pick_value(0, 65536), pick_value(0, 65536));
  endtask

  // Zero, full-scale, unit, single-thruster and alternating commands at reset registers
  task automatic test_reset_defaults();
    tfm_in_t cmd;
    int      k;
    send_cmd('0);
    send_cmd({8{16'sh7FFF}});
    send_cmd({8{16'sh8000}});
    send_cmd({8{16'sh0001}});
    send_cmd({8{16'shFFFF}});
    for (k = 0; k < 8; k++) begin
      cmd = '0;
      cmd[(7 - k) * CMD_W +: CMD_W] = 16'sh7FFF;
      send_cmd(cmd);
    end
    send_cmd({4{16'sh7FFF, 16'sh8000}});
    send_cmd({4{16'sh8000, 16'sh7FFF}});
  endtask

  // Register range ends with the largest commands and a random command set
  task automatic test_register_extremes();
    apply_config(-131072, -131072, 0, 0, 0, 0, 0);
    send_cmd({8{16'sh7FFF}});
    send_cmd({8{16'sh8000}});
    send_cmd({4{16'sh7FFF, 16'sh8000}});
    send_cmd(rand_cmd_set());
    apply_config(131071, -131072, 65535, 65535, 65535, 65536, 65536);
    send_cmd({8{16'sh7FFF}});
    send_cmd({8{16'sh8000}});
    send_cmd({4{16'sh8000, 16'sh7FFF}});
    send_cmd(rand_cmd_set());
  endtask

  // Random command sets under a series of random register settings
  task automatic test_random_mixing();
    int p;
    int k;
    for (p = 0; p < 4; p++) begin
      apply_random_config();
      for (k = 0; k < 350; k++) send_cmd(rand_cmd_set());
    end
  endtask

  // Back-to-back traffic with neither side idling
  task automatic test_full_rate();
    int k;
    apply_config(131071, 131071, 65535, 65535, 65535, 65536, 65536);
    quiet <= 1'b1;
    for (k = 0; k < 300; k++) send_cmd(rand_cmd_set());
    quiet <= 1'b0;
  endtask

  // Hold the output off long enough for the pipeline to fill and stall the input
  task automatic test_output_hold_off();
    int k;
    apply_random_config();
    hold_token <= hold_token + 1;
    for (k = 0; k < 250; k++) send_cmd(rand_cmd_set());
  endtask

  // Drive the output stall: long hold-off on request, else random or none
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic check_field(input string label, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] %s mismatch: expected %0d (0x%h) got %0d (0x%h)", $time, label,
                 $signed(want), want, $signed(got), got);
    end
  endtask

  // Compare each accepted result transaction with the oldest prediction
  always @(posedge clk) begin
    tfm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_wrench.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result arrived with nothing pending", $time);
      end else begin
        want = expected_wrench.pop_front();
        check_field("force_x", out_data.force_x, want.force_x);
        check_field("force_y", out_data.force_y, want.force_y);
        check_field("force_z", out_data.force_z, want.force_z);
        check_field("torque_x", out_data.torque_x, want.torque_x);
        check_field("torque_y", out_data.torque_y, want.torque_y);
        check_field("torque_z", out_data.torque_z, want.torque_z);
        check_field("saturated", OUT_W'(out_data.saturated), OUT_W'(want.saturated));
        wrenches_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_wrench.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_mixing();
    test_full_rate();
    test_output_hold_off();
    in_valid <= 1'b0;
    while (expected_wrench.size() != 0) @(posedge clk);
    repeat (NSTG + 4) @(posedge clk);
    $display("Checked %0d results from %0d command sets under %0d register settings",
             wrenches_checked, sets_sent, settings_used);
    $display("Run included extreme commands and coefficients, a full-rate burst %s%0d%s",
             "and a ", HOLD_LEN, "-cycle output hold-off");
    if (mismatches == 0 && expected_wrench.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               expected_wrench.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
